>>> design/cmra_pkg.sv
// ----------------------------------------------------------------------------
// cmra_pkg
// Shared sizes, codes and types of the cell map run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmra_pkg;

  // chunk holds 2^CELL_INDEX_BITS cells
  localparam int unsigned CELL_INDEX_BITS = 12;
  localparam int unsigned IDX_W           = CELL_INDEX_BITS;
  localparam int unsigned CNT_W           = CELL_INDEX_BITS + 1;
  localparam int unsigned NCELL           = 1 << CELL_INDEX_BITS;

  // map row layout: LANES cells of two bits per memory word
  localparam int unsigned LANE_BITS = (CELL_INDEX_BITS > 6) ? 5 : CELL_INDEX_BITS - 2;
  localparam int unsigned LANES     = 1 << LANE_BITS;
  localparam int unsigned ROW_BITS  = CELL_INDEX_BITS - LANE_BITS;
  localparam int unsigned ROWS      = 1 << ROW_BITS;

  typedef logic [1:0]           cell_t;
  typedef cell_t [LANES-1:0]    word_t;
  typedef logic [LANE_BITS-1:0] lane_t;
  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [ROW_BITS:0]    row_ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cell_t CELL_FREE = 2'd0;
  localparam cell_t CELL_HEAD = 2'd1;
  localparam cell_t CELL_CONT = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FIND  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_NOTHEAD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_AMARK,
    S_FREE,
    S_FIND,
    S_DONE
  } state_e;

  // one read port and one write port of the cell map
  typedef struct packed {
    logic  rd_en;
    row_t  rd_row;
    logic  wr_en;
    row_t  wr_row;
    word_t wr_data;
  } map_req_t;

endpackage

`default_nettype wire

>>> design/cmra_map_mem.sv
// ----------------------------------------------------------------------------
// cmra_map_mem
// Cell map storage: one row of cells per word, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmra_map_mem
  import cmra_pkg::*;
(
  input  wire logic     clk_i,
  input  wire map_req_t req_i,
  output logic          [2*LANES-1:0] rd_data_o
);

  word_t mem_q [ROWS];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_row] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_row];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> design/cell_map_run_allocator_top.sv
// ----------------------------------------------------------------------------
// cell_map_run_allocator_top
// Next-fit allocator of contiguous cell runs over a two-bit-per-cell map.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one command per transfer:
//   allocate a run of count_i cells, free a run from its head cell_index_i, or
//   find the head of the run holding cell_index_i. Every command returns one
//   result transfer on the output channel (status_o, result_index_o).
//   The map lives in a memory of 128 rows of 32 cells. Each command walks the
//   rows it needs, one row per cycle, through the registered read port:
//     allocate: scans rows from the rover, then marks the rows of the run; a
//               failed first scan from the rover restarts at row 0.
//     free:     walks the rows the run covers.
//     find:     walks the rows back to the head.
//   Rejected commands (zero or oversize count, bad range, unused code) answer
//   without walking the map. One command is in flight at a time; in_ready_o
//   is high only while the block waits for a command. After reset the map is
//   cleared by a pass over all 128 rows, during which no command is taken.
//   The result sits in an output register, so a command may be taken while a
//   result waits; a stalled receiver then holds the next result in the block
//   until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_map_run_allocator_top
  import cmra_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [IDX_W-1:0] cell_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      result_index_o
);

  typedef logic [CNT_W:0] wide_t;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e   state_q, state_d;
  cnt_t     rover_q, rover_d;
  logic     pass_q, pass_d;
  logic     rd_vld_q, rd_vld_d;
  row_t     clr_row_q, clr_row_d;
  logic     out_valid_q, out_valid_d;

  cnt_t     cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  cnt_t     lim_q, lim_d;
  cnt_t     start_q, start_d;
  cnt_t     run_q, run_d;
  cnt_t     head_q, head_d;
  logic [IDX_W-1:0] last_q, last_d;
  row_ptr_t iss_row_q, iss_row_d;
  row_t     rd_row_q, rd_row_d;
  status_e  res_status_q, res_status_d;
  cnt_t     res_index_q, res_index_d;
  status_e  out_status_q, out_status_d;
  cnt_t     out_index_q, out_index_d;

  map_req_t req;
  word_t    rd_data;

  cmra_map_mem u_map_mem (
    .clk_i    (clk_i),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  logic in_xfer;
  logic out_free;
  logic iss_more;
  logic rd_last;
  logic rd_first;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign iss_more   = !iss_row_q[ROW_BITS];
  assign rd_last    = &rd_row_q;
  // row holding the command's own cell (free walks up from it, find walks down)
  assign rd_first   = (rd_row_q == idx_q[IDX_W-1:LANE_BITS]);

  // --------------------------------------------------------------------------
  // command decode at the input transfer
  // --------------------------------------------------------------------------
  wide_t   lim_wide;
  state_e  dec_state;
  status_e dec_status;
  logic    dec_rover_clr;

  always_comb begin
    lim_wide      = (count_i == '0) ? wide_t'(NCELL)
                                    : wide_t'(cell_index_i) + wide_t'(count_i);
    dec_state     = S_DONE;
    dec_status    = STAT_RANGE;
    dec_rover_clr = 1'b0;
    unique case (cmd_i)
      CMD_ALLOC: begin
        if (count_i == '0) begin
          dec_status = STAT_NOSPACE;
        end else if (count_i > cnt_t'(NCELL)) begin
          // no run can fit: both scans fail, so the rover ends at zero
          dec_status    = STAT_NOSPACE;
          dec_rover_clr = 1'b1;
        end else begin
          dec_state = S_ASCAN;
        end
      end
      CMD_FREE: begin
        if (lim_wide > wide_t'(NCELL)) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_state = S_FREE;
        end
      end
      CMD_FIND: begin
        dec_state = S_FIND;
      end
      default: begin
        dec_status = STAT_RANGE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // allocate scan over one row: free-run length ending at each lane
  // --------------------------------------------------------------------------
  logic [LANES-1:0] avail;
  logic [LANES-1:0] hit;
  cnt_t             run_end [LANES];
  logic             scan_hit;
  lane_t            hit_lane;
  cnt_t             hit_head;
  cnt_t             hit_last;
  logic             start_row;

  always_comb begin
    logic found;
    int   pos;
    start_row = (rd_row_q == start_q[IDX_W-1:LANE_BITS]);
    for (int p = 0; p < LANES; p++) begin
      // cells below the scan start count as taken
      avail[p] = (rd_data[p] == CELL_FREE) &&
                 (!start_row || (lane_t'(p) >= start_q[LANE_BITS-1:0]));
    end
    for (int p = 0; p < LANES; p++) begin
      found = 1'b0;
      pos   = 0;
      for (int q = 0; q <= p; q++) begin
        if (!avail[q]) begin
          found = 1'b1;
          pos   = q;
        end
      end
      run_end[p] = found ? (cnt_t'(p) - cnt_t'(pos)) : (run_q + cnt_t'(p + 1));
      hit[p]     = avail[p] && (run_end[p] >= cnt_q);
    end
    scan_hit = |hit;
    hit_lane = '0;
    for (int p = LANES - 1; p >= 0; p--) begin
      if (hit[p]) begin
        hit_lane = lane_t'(p);
      end
    end
    hit_head = cnt_t'({rd_row_q, hit_lane}) + cnt_t'(1) - cnt_q;
    hit_last = hit_head + cnt_q - cnt_t'(1);
  end

  // --------------------------------------------------------------------------
  // allocate marking of one row
  // --------------------------------------------------------------------------
  word_t mark_word;
  logic  mark_last;

  always_comb begin
    logic lo_ok;
    logic hi_ok;
    logic in_head_row;
    in_head_row = (rd_row_q == head_q[IDX_W-1:LANE_BITS]);
    mark_last   = (rd_row_q == last_q[IDX_W-1:LANE_BITS]);
    for (int p = 0; p < LANES; p++) begin
      lo_ok = !in_head_row || (lane_t'(p) >= head_q[LANE_BITS-1:0]);
      hi_ok = !mark_last || (lane_t'(p) <= last_q[LANE_BITS-1:0]);
      if (lo_ok && hi_ok) begin
        mark_word[p] = (in_head_row && (lane_t'(p) == head_q[LANE_BITS-1:0])) ?
                       CELL_HEAD : CELL_CONT;
      end else begin
        mark_word[p] = rd_data[p];
      end
    end
  end

  // --------------------------------------------------------------------------
  // free of one row: clear from the head up to the first stop lane
  // --------------------------------------------------------------------------
  logic [LANES-1:0] fr_stop;
  logic             fr_found;
  lane_t            fr_lane;
  logic             fr_head_ok;
  word_t            fr_word;
  cnt_t             fr_end;

  always_comb begin
    logic lo_ok;
    for (int p = 0; p < LANES; p++) begin
      fr_stop[p] = (!rd_first || (lane_t'(p) > idx_q[LANE_BITS-1:0])) &&
                   ((rd_data[p] != CELL_CONT) ||
                    (cnt_t'({rd_row_q, lane_t'(p)}) >= lim_q));
    end
    fr_found = |fr_stop;
    fr_lane  = '0;
    for (int p = LANES - 1; p >= 0; p--) begin
      if (fr_stop[p]) begin
        fr_lane = lane_t'(p);
      end
    end
    fr_head_ok = (rd_data[idx_q[LANE_BITS-1:0]] == CELL_HEAD);
    for (int p = 0; p < LANES; p++) begin
      lo_ok = !rd_first || (lane_t'(p) >= idx_q[LANE_BITS-1:0]);
      if (lo_ok && (!fr_found || (lane_t'(p) < fr_lane))) begin
        fr_word[p] = CELL_FREE;
      end else begin
        fr_word[p] = rd_data[p];
      end
    end
    // without a stop lane the walk only ends at the last row, with the limit at the end
    fr_end = fr_found ? cnt_t'({rd_row_q, fr_lane}) : cnt_t'(NCELL);
  end

  // --------------------------------------------------------------------------
  // find of one row: nearest cell at or below the start that is no continuation
  // --------------------------------------------------------------------------
  logic [LANES-1:0] fd_cand;
  logic             fd_found;
  lane_t            fd_lane;
  lane_t            fd_top;
  logic             fd_is_head;

  always_comb begin
    fd_top = rd_first ? idx_q[LANE_BITS-1:0] : '1;
    for (int p = 0; p < LANES; p++) begin
      fd_cand[p] = (lane_t'(p) <= fd_top) && (rd_data[p] != CELL_CONT);
    end
    fd_found = |fd_cand;
    fd_lane  = '0;
    for (int p = 0; p < LANES; p++) begin
      if (fd_cand[p]) begin
        fd_lane = lane_t'(p);
      end
    end
    fd_is_head = (rd_data[fd_lane] == CELL_HEAD);
  end

  logic clr_end;
  logic scan_fail;
  logic mark_end;
  logic free_end;
  logic find_end;

  assign clr_end   = &clr_row_q;
  assign scan_fail = rd_vld_q && !scan_hit && rd_last;
  assign mark_end  = rd_vld_q && mark_last;
  assign free_end  = rd_vld_q && ((rd_first && !fr_head_ok) || fr_found || rd_last);
  assign find_end  = rd_vld_q && (fd_found || (rd_row_q == '0));

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_end) state_d = S_IDLE;
      S_IDLE:  if (in_xfer) state_d = dec_state;
      S_ASCAN: begin
        if (rd_vld_q && scan_hit) begin
          state_d = S_AMARK;
        end else if (scan_fail && pass_q) begin
          state_d = S_DONE;
        end
      end
      S_AMARK: if (mark_end) state_d = S_DONE;
      S_FREE:  if (free_end) state_d = S_DONE;
      S_FIND:  if (find_end) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    rover_d      = rover_q;
    pass_d       = pass_q;
    rd_vld_d     = 1'b0;
    rd_row_d     = rd_row_q;
    clr_row_d    = clr_row_q;
    out_valid_d  = out_valid_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    lim_d        = lim_q;
    start_d      = start_q;
    run_d        = run_q;
    head_d       = head_q;
    last_d       = last_q;
    iss_row_d    = iss_row_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    req          = '0;

    // drop the held result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // row walk: one read per cycle, data in the cycle after
    if ((state_q == S_ASCAN) || (state_q == S_AMARK) ||
        (state_q == S_FREE) || (state_q == S_FIND)) begin
      req.rd_en  = iss_more;
      req.rd_row = iss_row_q[ROW_BITS-1:0];
      rd_vld_d   = iss_more;
      rd_row_d   = iss_row_q[ROW_BITS-1:0];
      iss_row_d  = (state_q == S_FIND) ? iss_row_q - row_ptr_t'(1)
                                       : iss_row_q + row_ptr_t'(1);
    end

    unique case (state_q)
      S_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_row  = clr_row_q;
        req.wr_data = '0;
        clr_row_d   = clr_row_q + row_t'(1);
      end
      S_IDLE: begin
        if (in_xfer) begin
          cnt_d        = count_i;
          idx_d        = cell_index_i;
          lim_d        = lim_wide[CNT_W-1:0];
          res_status_d = dec_status;
          res_index_d  = '0;
          run_d        = '0;
          iss_row_d    = {1'b0, cell_index_i[IDX_W-1:LANE_BITS]};
          if (dec_rover_clr) begin
            rover_d = '0;
          end
          if (dec_state == S_ASCAN) begin
            if (rover_q == cnt_t'(NCELL)) begin
              // nothing left past the rover: go straight to the rescan from zero
              pass_d    = 1'b1;
              start_d   = '0;
              rover_d   = '0;
              iss_row_d = '0;
            end else begin
              pass_d    = 1'b0;
              start_d   = rover_q;
              iss_row_d = rover_q[CNT_W-1:LANE_BITS];
            end
          end
        end
      end
      S_ASCAN: begin
        if (rd_vld_q) begin
          if (scan_hit) begin
            head_d    = hit_head;
            last_d    = hit_last[IDX_W-1:0];
            rover_d   = hit_head + cnt_q;
            iss_row_d = hit_head[CNT_W-1:LANE_BITS];
            rd_vld_d  = 1'b0;
          end else if (rd_last) begin
            rover_d = '0;
            if (!pass_q) begin
              // rescan once from cell zero
              pass_d    = 1'b1;
              start_d   = '0;
              run_d     = '0;
              iss_row_d = '0;
              rd_vld_d  = 1'b0;
            end else begin
              res_status_d = STAT_NOSPACE;
              res_index_d  = '0;
            end
          end else begin
            run_d = run_end[LANES-1];
          end
        end
      end
      S_AMARK: begin
        if (rd_vld_q) begin
          req.wr_en   = 1'b1;
          req.wr_row  = rd_row_q;
          req.wr_data = mark_word;
          if (mark_last) begin
            res_status_d = STAT_OK;
            res_index_d  = head_q;
          end
        end
      end
      S_FREE: begin
        if (rd_vld_q) begin
          if (rd_first && !fr_head_ok) begin
            res_status_d = STAT_NOTHEAD;
            res_index_d  = '0;
          end else begin
            req.wr_en   = 1'b1;
            req.wr_row  = rd_row_q;
            req.wr_data = fr_word;
            if (fr_found || rd_last) begin
              res_status_d = STAT_OK;
              res_index_d  = fr_end;
            end
          end
        end
      end
      S_FIND: begin
        if (rd_vld_q) begin
          if (fd_found) begin
            res_status_d = fd_is_head ? STAT_OK : STAT_NOTHEAD;
            res_index_d  = fd_is_head ? cnt_t'({rd_row_q, fd_lane}) : '0;
          end else if (rd_row_q == '0) begin
            // walked down to cell zero inside a continuation
            res_status_d = STAT_NOTHEAD;
            res_index_d  = '0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
        end
      end
      default: begin
        clr_row_d = clr_row_q;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rover_q     <= '0;
      pass_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      pass_q      <= pass_d;
      rd_vld_q    <= rd_vld_d;
      clr_row_q   <= clr_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    idx_q        <= idx_d;
    lim_q        <= lim_d;
    start_q      <= start_d;
    run_q        <= run_d;
    head_q       <= head_d;
    last_q       <= last_d;
    iss_row_q    <= iss_row_d;
    rd_row_q     <= rd_row_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;

endmodule

`default_nettype wire

>>> design/cmra_checker.sv
// ----------------------------------------------------------------------------
// cmra_checker
// Port-level checks of the cell map run allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cmra_checker
  import cmra_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [1:0]       cmd_i,
  input wire logic [CNT_W-1:0] count_i,
  input wire logic [IDX_W-1:0] cell_index_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       status_o,
  input wire logic [CNT_W-1:0] result_index_o
);

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(result_index_o))
    else $error("result changed while stalled");

  // one command at a time: ready drops right after an input transfer
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  // any failing status carries a zero index
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (result_index_o == '0))
    else $error("nonzero index on failing status");

  // indices never reach past the chunk end
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_index_o <= cnt_t'(NCELL)))
    else $error("result index beyond chunk");

endmodule

bind cell_map_run_allocator_top cmra_checker u_cmra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .cmd_i         (cmd_i),
  .count_i       (count_i),
  .cell_index_i  (cell_index_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .result_index_o(result_index_o)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit cell run allocator.
// Drives allocate, free and find-head commands through the input channel and
// checks every result against a cycle-free shadow of the cell map and rover.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cmra_pkg::*;

  // expected answer of one command
  typedef struct packed {
    logic [1:0] status;
    cnt_t       index;
  } answer_t;

  // a run the bench knows to be live, so it can free it or look inside it
  typedef struct {
    int unsigned head;
    int unsigned len;
  } run_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [1:0]       cmd            = 2'd0;
  logic [CNT_W-1:0] count          = '0;
  logic [IDX_W-1:0] cell_index     = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [1:0]       status;
  logic [CNT_W-1:0] result_index;

  // shadow state of the block
  cell_t       shadow_map [NCELL];
  int unsigned next_fit_ptr;

  answer_t     answers_q [$];
  run_t        live_runs [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  int unsigned errors        = 0;
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_by_status [4];

  cell_map_run_allocator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .count_i        (count),
    .cell_index_i   (cell_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .result_index_o (result_index)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------

  // first cell at or after start that opens a free stretch of cells; NCELL if none
  function automatic int unsigned first_free_run(int unsigned start, int unsigned cells);
    int unsigned run;
    run = 0;
    for (int unsigned i = start; i < NCELL; i++) begin
      if (shadow_map[i] == CELL_FREE) begin
        run++;
        if (run >= cells) return i + 1 - cells;
      end else begin
        run = 0;
      end
    end
    return NCELL;
  endfunction

  // apply one command to the shadow map and return what the block must answer
  function automatic answer_t apply_command(logic [1:0] op, cnt_t cnt, logic [IDX_W-1:0] idx);
    answer_t     a;
    int unsigned h;
    int unsigned lim;
    int unsigned i;
    a.status = STAT_RANGE;
    a.index  = '0;
    if (op == CMD_ALLOC) begin
      if (cnt == 0 || cnt > NCELL) begin
        // an oversize request still fails both scans, which parks the rover at zero
        if (cnt != 0) next_fit_ptr = 0;
        a.status = STAT_NOSPACE;
      end else begin
        h = first_free_run((next_fit_ptr < NCELL) ? next_fit_ptr : NCELL, cnt);
        if (h >= NCELL) begin
          next_fit_ptr = 0;
          h = first_free_run(0, cnt);
        end
        if (h >= NCELL) begin
          a.status = STAT_NOSPACE;
        end else begin
          shadow_map[h] = CELL_HEAD;
          for (int unsigned j = h + 1; j < h + cnt; j++) shadow_map[j] = CELL_CONT;
          next_fit_ptr = h + cnt;
          a.status     = STAT_OK;
          a.index      = cnt_t'(h);
        end
      end
    end else if (op == CMD_FREE) begin
      lim = (cnt > 0) ? idx + cnt : NCELL;
      if (lim > NCELL) begin
        a.status = STAT_RANGE;
      end else if (shadow_map[idx] != CELL_HEAD) begin
        a.status = STAT_NOTHEAD;
      end else begin
        // clear the head, then continuation cells up to the limit or the run end
        i = idx;
        shadow_map[i] = CELL_FREE;
        i++;
        while (i < lim && shadow_map[i] == CELL_CONT) begin
          shadow_map[i] = CELL_FREE;
          i++;
        end
        a.status = STAT_OK;
        a.index  = cnt_t'(i);
      end
    end else if (op == CMD_FIND) begin
      i = idx;
      while (i > 0 && shadow_map[i] == CELL_CONT) i--;
      if (shadow_map[i] != CELL_HEAD) begin
        a.status = STAT_NOTHEAD;
      end else begin
        a.status = STAT_OK;
        a.index  = cnt_t'(i);
      end
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one command per call; valid holds until the transfer
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [1:0] op, input int unsigned cnt,
                          input int unsigned idx, output answer_t ans);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    count      <= cnt_t'(cnt);
    cell_index <= idx[IDX_W-1:0];
    do @(posedge clk_i); while (!in_ready);

    // accepted: advance the shadow and queue the answer
    ans = apply_command(op, cnt_t'(cnt), idx[IDX_W-1:0]);
    answers_q.push_back(ans);
    n_sent++;
    n_by_status[ans.status]++;
    if (ans.status == STAT_OK && op == CMD_ALLOC) begin
      live_runs.push_back('{head: ans.index, len: cnt});
    end else if (ans.status == STAT_OK && op == CMD_FREE) begin
      // drop every tracked run that started at the freed head
      for (int k = live_runs.size() - 1; k >= 0; k--) begin
        if (live_runs[k].head == idx) live_runs.delete(k);
      end
    end
  endtask

  // drop valid and hold the channel quiet
  task automatic release_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_answered();
    release_input();
    while (answers_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every transfer against the oldest expected answer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d result_index=%0d",
                 $time, status, result_index);
      end else begin
        want = answers_q.pop_front();
        n_checked++;
        if (status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
        end
        if (result_index !== want.index) begin
          errors++;
          $display("%0t: result_index mismatch: expected %0d, actual %0d",
                   $time, want.index, result_index);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty map: lookups fail, bad counts and the unused code are rejected
  task automatic test_empty_map_and_rejects();
    answer_t a;
    send_cmd(CMD_FIND,  0,    0,    a);
    send_cmd(CMD_FREE,  0,    0,    a);
    send_cmd(CMD_ALLOC, 0,    0,    a);
    send_cmd(CMD_ALLOC, 4097, 0,    a);
    send_cmd(CMD_ALLOC, 8191, 4095, a);
    send_cmd(2'd3,      4096, 4095, a);
  endtask

  // whole-chunk runs, a full map, and the rover wrapping back to zero
  task automatic test_full_chunk_and_wrap();
    answer_t a;
    send_cmd(CMD_ALLOC, NCELL,     0,           a);
    send_cmd(CMD_FIND,  0,         NCELL - 1,   a);
    send_cmd(CMD_ALLOC, 1,         0,           a);
    send_cmd(CMD_FREE,  0,         0,           a);
    send_cmd(CMD_ALLOC, NCELL - 8, 0,           a);
    send_cmd(CMD_ALLOC, 8,         0,           a);
    send_cmd(CMD_ALLOC, 1,         0,           a);
    send_cmd(CMD_FREE,  8,         NCELL - 8,   a);
    send_cmd(CMD_ALLOC, 1,         0,           a);
    send_cmd(CMD_FREE,  0,         0,           a);
    send_cmd(CMD_FREE,  0,         NCELL - 8,   a);
  endtask

  // lookups inside a run, a free at a non-head, a short free leaving a tail
  // with no head, a free cut short by the run end, and a range past the chunk
  task automatic test_partial_free_and_orphans();
    answer_t     a;
    int unsigned h1;
    int unsigned h2;
    send_cmd(CMD_ALLOC, 5, 0, a);
    h1 = a.index;
    send_cmd(CMD_ALLOC, 3, 0, a);
    h2 = a.index;
    send_cmd(CMD_FIND,  0, h2 + 2,    a);
    send_cmd(CMD_FREE,  0, h2 + 1,    a);
    send_cmd(CMD_FREE,  2, h2,        a);
    send_cmd(CMD_FIND,  0, h2 + 2,    a);
    send_cmd(CMD_FREE,  6, h1,        a);
    send_cmd(CMD_FREE,  2, NCELL - 1, a);
  endtask

  // hold the receiver off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    answer_t a;
    hold_request = 600;
    for (int k = 0; k < 10; k++) begin
      if (k % 2 == 0) send_cmd(CMD_ALLOC, $urandom_range(1, 6), 0, a);
      else            send_cmd(CMD_FIND, 0, $urandom_range(NCELL - 1), a);
    end
  endtask

  // pause the sender until every answer is in, then resume
  task automatic test_drain_pause();
    answer_t a;
    wait_all_answered();
    repeat (3) send_cmd(CMD_FIND, 0, $urandom_range(NCELL - 1), a);
  endtask

  // mostly well-formed traffic on tracked runs, with some noise mixed in
  task automatic test_random_traffic(input int unsigned items);
    answer_t     a;
    int unsigned r;
    int unsigned k;
    int unsigned cnt;
    int unsigned alloc_share;
    run_t        run;
    for (int unsigned n = 0; n < items; n++) begin
      r           = $urandom_range(99);
      alloc_share = (live_runs.size() > 120) ? 30 : 48;
      if (live_runs.size() == 0 || r < alloc_share) begin
        k = $urandom_range(99);
        if (k < 70)      cnt = $urandom_range(1, 16);
        else if (k < 95) cnt = $urandom_range(17, 128);
        else if (k < 99) cnt = $urandom_range(129, 1024);
        else             cnt = $urandom_range(1025, NCELL);
        send_cmd(CMD_ALLOC, cnt, $urandom_range(NCELL - 1), a);
      end else if (r < 78) begin
        run = live_runs[$urandom_range(live_runs.size() - 1)];
        k   = $urandom_range(99);
        if (k < 60)                      cnt = 0;
        else if (k < 80)                 cnt = run.len;
        else if (k < 90 && run.len > 1)  cnt = $urandom_range(1, run.len - 1);
        else                             cnt = run.len + $urandom_range(1, 20);
        send_cmd(CMD_FREE, cnt, run.head, a);
      end else if (r < 90) begin
        run = live_runs[$urandom_range(live_runs.size() - 1)];
        send_cmd(CMD_FIND, $urandom_range(CNT_W'(NCELL)),
                 run.head + $urandom_range(run.len - 1), a);
      end else begin
        // noise: any code, random index; keep noisy allocations small
        k = $urandom_range(3);
        if (k == CMD_ALLOC)              cnt = $urandom_range(40);
        else if ($urandom_range(7) == 0) cnt = $urandom_range((1 << CNT_W) - 1);
        else                             cnt = $urandom_range(NCELL);
        send_cmd(k[1:0], cnt, $urandom_range(NCELL - 1), a);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NCELL; i++) shadow_map[i] = CELL_FREE;
    next_fit_ptr = 0;
    for (int i = 0; i < 4; i++) n_by_status[i] = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part with idling on both sides
    send_idle_pct = 20;
    recv_idle_pct = 63;
    test_empty_map_and_rejects();
    test_full_chunk_and_wrap();
    test_partial_free_and_orphans();
    test_backpressure();
    test_drain_pause();

    // random part: receiver idles, then sender idles, then nobody does
    test_random_traffic(630);
    wait_all_answered();
    send_idle_pct = 63;
    recv_idle_pct = 20;
    test_random_traffic(630);
    wait_all_answered();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(630);

    // drain, then watch for stray results
    wait_all_answered();
    repeat (400) @(posedge clk_i);

    $display("Covered %0d commands (%0d checked): ok %0d, no space %0d, range %0d, not head %0d",
             n_sent, n_checked, n_by_status[STAT_OK], n_by_status[STAT_NOSPACE],
             n_by_status[STAT_RANGE], n_by_status[STAT_NOTHEAD]);
    $display("Runs tracked at end: %0d, rover at %0d, mismatches %0d",
             live_runs.size(), next_fit_ptr, errors);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12000000;
    $display("Timeout with %0d answers outstanding", answers_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
